// ----- sv/nfrp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfrp_pkg
// Shared types and constants of the navigation frame resync parser.
// ----------------------------------------------------------------------------
package nfrp_pkg;

  // Frame layout
  localparam logic [7:0] FRAME_HEAD = 8'h55;
  localparam logic [7:0] FRAME_TAIL = 8'h6B;
  localparam logic [7:0] CMD_LINE   = 8'h01;
  localparam logic [7:0] CMD_PATH   = 8'h02;
  localparam logic [7:0] SIGN_NEG   = 8'h00;
  localparam logic [7:0] SIGN_POS   = 8'h01;
  localparam int unsigned FRAME_LEN = 12;
  localparam int unsigned CNT_W     = 4;

  // Frame byte positions
  localparam int unsigned POS_CMD   = 1;
  localparam int unsigned POS_X_HI  = 2;
  localparam int unsigned POS_X_LO  = 3;
  localparam int unsigned POS_Y_HI  = 4;
  localparam int unsigned POS_Y_LO  = 5;
  localparam int unsigned POS_SIGN  = 6;
  localparam int unsigned POS_YAW   = 7;
  localparam int unsigned POS_LIN_H = 8;
  localparam int unsigned POS_LIN_L = 9;
  localparam int unsigned POS_ANG   = 10;
  localparam int unsigned POS_TAIL  = 11;

  localparam int unsigned OUT_W = 72;

  // One received byte with its classification flags
  typedef struct packed {
    logic [7:0] data;
    logic       is_head;
    logic       is_cmd;
    logic       is_tail;
    logic       is_sign;
  } nfrp_byte_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } nfrp_state_e;

  // Classify one byte
  function automatic nfrp_byte_t classify(input logic [7:0] b);
    nfrp_byte_t r;
    r.data    = b;
    r.is_head = (b == FRAME_HEAD);
    r.is_cmd  = (b == CMD_LINE) || (b == CMD_PATH);
    r.is_tail = (b == FRAME_TAIL);
    r.is_sign = (b == SIGN_NEG) || (b == SIGN_POS);
    return r;
  endfunction

endpackage

// ----- sv/nfrp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfrp_front
// Accepts stream bytes, tags them with header/command/tail/sign flags and
// buffers them in a small queue toward the back end.
// ----------------------------------------------------------------------------
module nfrp_front import nfrp_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_data_i,
  output logic       q_valid_o,
  input  logic       q_ready_i,
  output nfrp_byte_t q_item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

  nfrp_byte_t        mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign in_ready_o = (cnt_q != FULL_CNT);
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the classified byte
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= classify(in_data_i);
    end
  end

endmodule

// ----- sv/nfrp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfrp_back
// Holds the 12-byte window, resynchronizes on the header one byte per cycle
// and decodes complete frames into a registered result.
// ----------------------------------------------------------------------------
module nfrp_back import nfrp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  nfrp_byte_t       q_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] out_data_o
);

  nfrp_state_e      st_q, st_d;
  nfrp_byte_t       win_q [FRAME_LEN];
  nfrp_byte_t       win_d [FRAME_LEN];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_data_q;
  logic             out_free, frame_ok, emit, drop;
  logic [8:0]       yaw;
  logic [OUT_W-1:0] frame_word;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_LEN);

  assign out_free  = !out_valid_q || out_ready_i;
  assign q_ready_o = (st_q == ST_IDLE);
  assign frame_ok  = win_q[0].is_head && win_q[POS_CMD].is_cmd &&
                     win_q[POS_TAIL].is_tail && win_q[POS_SIGN].is_sign;

  // One resync decision per cycle while scanning
  always_comb begin
    drop = 1'b0;
    emit = 1'b0;
    if (st_q == ST_SCAN && cnt_q != '0) begin
      if (!win_q[0].is_head) begin
        drop = 1'b1;
      end else if (cnt_q >= CNT_W'(2)) begin
        if (!win_q[POS_CMD].is_cmd) begin
          drop = 1'b1;
        end else if (cnt_q == FULL_CNT) begin
          if (!frame_ok) begin
            drop = 1'b1;
          end else begin
            emit = out_free;
          end
        end
      end
    end
  end

  // Decode the frame fields
  always_comb begin
    yaw = (win_q[POS_SIGN].data == SIGN_NEG) ?
          9'(9'd0 - {1'b0, win_q[POS_YAW].data}) : {1'b0, win_q[POS_YAW].data};
    frame_word = {6'd0,
                  win_q[POS_ANG].data,
                  win_q[POS_LIN_H].data, win_q[POS_LIN_L].data,
                  yaw,
                  win_q[POS_Y_HI].data, win_q[POS_Y_LO].data,
                  win_q[POS_X_HI].data, win_q[POS_X_LO].data,
                  (win_q[POS_CMD].data == CMD_PATH)};
  end

  // Next window, count and state
  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    for (int k = 0; k < FRAME_LEN; k++) begin
      win_d[k] = win_q[k];
    end
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          for (int k = 0; k < FRAME_LEN; k++) begin
            if (cnt_q == CNT_W'(k)) begin
              win_d[k] = q_item_i;
            end
          end
          cnt_d = cnt_q + 1'b1;
          st_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (drop) begin
          for (int k = 0; k < FRAME_LEN - 1; k++) begin
            win_d[k] = win_q[k + 1];
          end
          cnt_d = cnt_q - 1'b1;
        end else if (emit) begin
          cnt_d = '0;
          st_d  = ST_IDLE;
        end else if (!(cnt_q == FULL_CNT && frame_ok)) begin
          // nothing left to resolve until the next byte
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < FRAME_LEN; k++) begin
      win_q[k] <= win_d[k];
    end
    if (emit) begin
      out_data_q <= frame_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Window never overfills
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT) else $error("window count above frame length");

  // A new byte only lands in a window with room
  a_idle_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> (cnt_q < FULL_CNT)) else $error("full window while idle");

  // Emit only from a full window that starts on a header
  a_emit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (cnt_q == FULL_CNT && win_q[0].is_head && out_free))
    else $error("emit from an incomplete window");

  // Window empties after a frame
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (cnt_q == '0 && out_valid_q && st_q == ST_IDLE))
    else $error("window not cleared after frame");

endmodule

// ----- sv/nav_frame_resync_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nav_frame_resync_parser_top
// Parses a byte stream into 12-byte navigation frames with header resync.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                         Item
// s_axis   in   s_axis_tvalid_i/tready_o/tdata  one received byte
// m_axis   out  m_axis_tvalid_o/tready_i/tdata  one decoded frame
//
// An accepted byte is written into the input queue. The back end takes a
// queued byte only while idle, then its sequencer drops window positions one
// at a time and then emits a frame or stops, before it takes the next byte;
// the single-step shift of the window sets this pace. The queue keeps
// accepting during that time until it fills.
// A decoded frame waits in an output register; a stalled output holds the
// sequencer only when a second frame completes. Reset clears the window
// count, the queue and the output valid.
// ----------------------------------------------------------------------------
module nav_frame_resync_parser_top import nfrp_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // [0] nav_mode, [16:1] target_x,
                                        // [32:17] target_y, [41:33] yaw_degrees,
                                        // [57:42] max_linear_speed,
                                        // [65:58] max_angular_speed, rest zero
);

  logic       q_valid, q_ready;
  nfrp_byte_t q_item;

  nfrp_front #(
    .DEPTH(FIFO_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .in_data_i (s_axis_tdata_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  nfrp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_item_i   (q_item),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte stream test of the navigation frame resync parser. A frame tracker
// rebuilds the sliding window from every accepted byte, predicts each decoded
// frame and compares the frames the block delivers field by field. Stimulus
// is a short directed prelude, then mostly well-formed frames with random
// content mixed with broken frames and noise, under bursty input and a
// stalling output.
// ----------------------------------------------------------------------------
module testbench;
  import nfrp_pkg::*;

  localparam int ITEMS       = 550;
  localparam int LIMIT       = 200000;
  localparam int SETTLE      = 100;

  // Expected content of one decoded frame
  typedef struct packed {
    logic               mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [8:0]  yaw;
    logic [15:0]        lin;
    logic [7:0]         ang;
  } nav_frame_t;

  // Kinds of random byte sequences
  typedef enum int {
    SEQ_GOOD, SEQ_BAD_TAIL, SEQ_BAD_SIGN, SEQ_BAD_CMD, SEQ_CUT, SEQ_NOISE
  } seq_kind_e;

  // Output stall patterns
  typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT } rx_mode_e;

  // Window tracker and frame checker
  class frame_tracker;
    logic [7:0] win [FRAME_LEN];
    int         win_cnt;
    nav_frame_t frames_due[$];
    int         errors;

    function new();
      win_cnt = 0;
      errors  = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void drop_front(int n);
      if (n == 0) return;
      if (n >= win_cnt) begin
        win_cnt = 0;
        return;
      end
      for (int k = 0; k < win_cnt - n; k++) win[k] = win[k + n];
      win_cnt -= n;
    endfunction

    function bit valid_cmd(logic [7:0] c);
      return (c == CMD_LINE) || (c == CMD_PATH);
    endfunction

    // Shift one byte in and resync; queue a frame when one completes
    function void take_byte(logic [7:0] b);
      int         i;
      bit         done;
      bit         emitted;
      nav_frame_t f;
      logic [8:0] mag;
      done    = 0;
      emitted = 0;
      if (win_cnt >= FRAME_LEN) drop_front(1);
      win[win_cnt] = b;
      win_cnt++;
      while (win_cnt > 0 && !done) begin
        i = 0;
        while (i < win_cnt && win[i] != FRAME_HEAD) i++;
        drop_front(i);
        if (win_cnt < 2) begin
          done = 1;
        end else if (!valid_cmd(win[POS_CMD])) begin
          drop_front(1);
        end else if (win_cnt < FRAME_LEN) begin
          done = 1;
        end else if (win[POS_TAIL] != FRAME_TAIL ||
                     !(win[POS_SIGN] == SIGN_NEG || win[POS_SIGN] == SIGN_POS)) begin
          drop_front(1);
        end else begin
          if (!emitted) begin
            mag   = {1'b0, win[POS_YAW]};
            f.mode = (win[POS_CMD] == CMD_PATH);
            f.x    = {win[POS_X_HI], win[POS_X_LO]};
            f.y    = {win[POS_Y_HI], win[POS_Y_LO]};
            f.yaw  = (win[POS_SIGN] == SIGN_NEG) ? (9'd0 - mag) : mag;
            f.lin  = {win[POS_LIN_H], win[POS_LIN_L]};
            f.ang  = win[POS_ANG];
            frames_due.push_back(f);
            emitted = 1;
          end
          drop_front(FRAME_LEN);
        end
      end
    endfunction

    // Compare a delivered frame with the oldest one due
    task match_frame(logic [71:0] d);
      nav_frame_t w;
      if (frames_due.size() == 0) begin
        report($sformatf("frame %h arrived with none due", d));
        return;
      end
      w = frames_due.pop_front();
      if (d[0] !== w.mode)
        report($sformatf("nav_mode got %0d want %0d", d[0], w.mode));
      if (d[16:1] !== w.x)
        report($sformatf("target_x got %0d want %0d", $signed(d[16:1]), w.x));
      if (d[32:17] !== w.y)
        report($sformatf("target_y got %0d want %0d", $signed(d[32:17]), w.y));
      if (d[41:33] !== w.yaw)
        report($sformatf("yaw_degrees got %0d want %0d", $signed(d[41:33]), w.yaw));
      if (d[57:42] !== w.lin)
        report($sformatf("max_linear_speed got %0d want %0d", d[57:42], w.lin));
      if (d[65:58] !== w.ang)
        report($sformatf("max_angular_speed got %0d want %0d", d[65:58], w.ang));
      if (d[71:66] !== 6'd0)
        report($sformatf("pad bits got %b", d[71:66]));
    endtask
  endclass

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'd0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [71:0] m_data;

  frame_tracker board = new();
  int          sent       = 0;
  int          burst_left = 8;
  int          cycles     = 0;
  int          rx_phase   = 0;
  rx_mode_e    rx_mode    = RX_OPEN;

  nav_frame_resync_parser_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watch both handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) board.take_byte(s_data);
      if (m_valid && m_ready) board.match_frame(m_data);
    end
  end

  // Stall the output on a changing pattern
  always @(posedge clk_i) begin
    rx_phase++;
    if (rx_phase % 50 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   m_ready <= 1'b1;
      RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
      default:   m_ready <= (rx_phase % 3 == 0);
    endcase
  end

  // Abort a hung run
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Send one byte; when the burst runs out, usually pause for a gap, then start a new burst
  task automatic put_byte(input logic [7:0] b);
    int gap;
    s_data  <= b;
    s_valid <= 1'b1;
    do @(posedge clk_i); while (!s_ready);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
    end
  endtask

  // Hold the input until every due frame has arrived
  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (board.frames_due.size() != 0);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] x,
                            input logic [15:0] y, input logic [7:0] sign,
                            input logic [7:0] deg, input logic [15:0] lin,
                            input logic [7:0] ang, input logic [7:0] tail);
    put_byte(FRAME_HEAD);
    put_byte(cmd);
    put_byte(x[15:8]);
    put_byte(x[7:0]);
    put_byte(y[15:8]);
    put_byte(y[7:0]);
    put_byte(sign);
    put_byte(deg);
    put_byte(lin[15:8]);
    put_byte(lin[7:0]);
    put_byte(ang);
    put_byte(tail);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_cmd();
    return $urandom_range(0, 1) ? CMD_PATH : CMD_LINE;
  endfunction

  function automatic logic [7:0] pick_sign();
    return $urandom_range(0, 1) ? SIGN_POS : SIGN_NEG;
  endfunction

  initial begin
    seq_kind_e  kind;
    int         roll;
    int         n;
    bit         paused;
    logic [7:0] b;
    paused = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: noise, a false header, then two frames at the field extremes
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(FRAME_HEAD);
    put_byte(8'h03);
    send_frame(CMD_PATH, 16'h8000, 16'h7FFF, SIGN_NEG, 8'h00, 16'hFFFF, 8'hFF,
               FRAME_TAIL);
    send_frame(CMD_LINE, 16'h7FFF, 16'h8000, SIGN_POS, 8'hFF, 16'h0000, 8'h00,
               FRAME_TAIL);
    drain();

    // Random: mostly good frames, some broken frames and noise
    while (sent < ITEMS) begin
      if (!paused && sent >= ITEMS / 2) begin
        drain();
        paused = 1;
      end
      roll = $urandom_range(0, 99);
      if      (roll < 64) kind = SEQ_GOOD;
      else if (roll < 70) kind = SEQ_BAD_TAIL;
      else if (roll < 76) kind = SEQ_BAD_SIGN;
      else if (roll < 83) kind = SEQ_BAD_CMD;
      else if (roll < 90) kind = SEQ_CUT;
      else                kind = SEQ_NOISE;
      case (kind)
        SEQ_GOOD: begin
          send_frame(pick_cmd(), pick_word(), pick_word(), pick_sign(), pick_byte(),
                     pick_word(), pick_byte(), FRAME_TAIL);
        end
        SEQ_BAD_TAIL: begin
          do b = 8'($urandom); while (b == FRAME_TAIL);
          send_frame(pick_cmd(), pick_word(), pick_word(), pick_sign(), pick_byte(),
                     pick_word(), pick_byte(), b);
        end
        SEQ_BAD_SIGN: begin
          b = 8'($urandom_range(2, 255));
          send_frame(pick_cmd(), pick_word(), pick_word(), b, pick_byte(),
                     pick_word(), pick_byte(), FRAME_TAIL);
        end
        SEQ_BAD_CMD: begin
          put_byte(FRAME_HEAD);
          do b = 8'($urandom); while (b == CMD_LINE || b == CMD_PATH);
          put_byte(b);
        end
        SEQ_CUT: begin
          put_byte(FRAME_HEAD);
          put_byte(pick_cmd());
          n = $urandom_range(0, 9);
          repeat (n) put_byte(pick_byte());
        end
        default: begin
          n = $urandom_range(1, 6);
          repeat (n) put_byte(($urandom_range(0, 3) == 0) ? FRAME_HEAD : 8'($urandom));
        end
      endcase
    end

    // Let the last frames and queued bytes drain out
    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
